FILE: src/cbf_pkg.sv
// shared types and constants for the cubic bezier flattener
package cbf_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W = 6;
    localparam int A_W = COORD_W + 3;
    localparam int B_W = COORD_W + 2;
    localparam int C_W = COORD_W + 1;

    localparam int NUM_POINTS_DEF = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             first;
        logic             last;
    } cbf_ctrl_t;

    typedef struct packed {
        logic signed [A_W-1:0]     a;
        logic signed [B_W-1:0]     b;
        logic signed [C_W-1:0]     c;
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] s;
    } cbf_terms_t;

endpackage

FILE: src/cbf_coef_rom.sv
// constant coefficient table: t^3, 3t^2 and 3t per sample index
module cbf_coef_rom #(
    parameter int NUM_POINTS = cbf_pkg::NUM_POINTS_DEF,
    parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic [cbf_pkg::IDX_W-1:0]  index,
    output logic [COEF_FRAC_BITS+1:0]  coef_a,
    output logic [COEF_FRAC_BITS+1:0]  coef_b,
    output logic [COEF_FRAC_BITS+1:0]  coef_c
);
    import cbf_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int DEPTH = 2 ** IDX_W;
    localparam longint unsigned SEG = longint'(NUM_POINTS - 1);

    logic [CW-1:0] tab_a [DEPTH];
    logic [CW-1:0] tab_b [DEPTH];
    logic [CW-1:0] tab_c [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_coef
        localparam longint unsigned I = longint'(g);
        localparam longint unsigned DA = SEG * SEG * SEG;
        localparam longint unsigned DB = SEG * SEG;
        localparam longint unsigned VA =
            (((I * I * I) << (COEF_FRAC_BITS + 1)) + DA) / (2 * DA);
        localparam longint unsigned VB =
            (((3 * I * I) << (COEF_FRAC_BITS + 1)) + DB) / (2 * DB);
        localparam longint unsigned VC =
            (((3 * I) << (COEF_FRAC_BITS + 1)) + SEG) / (2 * SEG);
        if (g < NUM_POINTS)
        begin : g_used
            assign tab_a[g] = CW'(VA);
            assign tab_b[g] = CW'(VB);
            assign tab_c[g] = CW'(VC);
        end
        else
        begin : g_unused
            assign tab_a[g] = '0;
            assign tab_b[g] = '0;
            assign tab_c[g] = '0;
        end
    end

    assign coef_a = tab_a[index];
    assign coef_b = tab_b[index];
    assign coef_c = tab_c[index];

endmodule

FILE: src/cbf_issue.sv
// curve intake, derived polynomial terms and sample index sequencer
module cbf_issue #(
    parameter int NUM_POINTS = cbf_pkg::NUM_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_a_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_a_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_b_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_b_y,
    input  logic                               advance,
    output logic                               issue_valid,
    output cbf_pkg::cbf_ctrl_t                 issue_ctrl,
    output cbf_pkg::cbf_terms_t                terms_x,
    output cbf_pkg::cbf_terms_t                terms_y
);
    import cbf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    cbf_terms_t       tx_reg, ty_reg;
    cbf_terms_t       tx_next, ty_next;
    logic             emit, last_emit, accept;

    function automatic cbf_terms_t derive(
        input logic signed [COORD_W-1:0] s,
        input logic signed [COORD_W-1:0] e,
        input logic signed [COORD_W-1:0] ca,
        input logic signed [COORD_W-1:0] cb
    );
        cbf_terms_t t;
        logic signed [A_W-1:0] dba;
        dba = A_W'(cb) - A_W'(ca);
        t.a = A_W'(s) - A_W'(e) + dba + (dba <<< 1);
        t.b = B_W'(ca) + B_W'(e) - (B_W'(cb) <<< 1);
        t.c = C_W'(cb) - C_W'(e);
        t.d = e;
        t.s = s;
        return t;
    endfunction

    assign emit = busy_reg && advance;
    assign last_emit = emit && (idx_reg == LAST_IDX);
    assign in_ready = !busy_reg || last_emit;
    assign accept = in_valid && in_ready;

    assign tx_next = derive(start_x, end_x, ctrl_a_x, ctrl_b_x);
    assign ty_next = derive(start_y, end_y, ctrl_a_y, ctrl_b_y);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next = idx_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next = '0;
        end
        else if (last_emit)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    assign issue_valid = busy_reg;
    assign issue_ctrl.index = idx_reg;
    assign issue_ctrl.first = (idx_reg == '0);
    assign issue_ctrl.last = (idx_reg == LAST_IDX);
    assign terms_x = tx_reg;
    assign terms_y = ty_reg;

endmodule

FILE: src/cbf_coord_path.sv
// one coordinate: multiply, sum, floor shift, offset, saturate
module cbf_coord_path #(
    parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               advance,
    input  logic [COEF_FRAC_BITS+1:0]          coef_a,
    input  logic [COEF_FRAC_BITS+1:0]          coef_b,
    input  logic [COEF_FRAC_BITS+1:0]          coef_c,
    input  cbf_pkg::cbf_terms_t                terms,
    input  cbf_pkg::cbf_ctrl_t                 ctrl,
    output logic signed [cbf_pkg::COORD_W-1:0] point
);
    import cbf_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int P_W = CW + 1 + A_W;
    localparam int SUM_W = P_W + 2;
    localparam int Q_W = SUM_W - COEF_FRAC_BITS;
    localparam int V_W = Q_W + 1;

    logic signed [CW:0]         ca_s, cb_s, cc_s;
    logic signed [P_W-1:0]      pa_next, pb_next, pc_next;
    logic signed [P_W-1:0]      pa_reg, pb_reg, pc_reg;
    logic signed [COORD_W-1:0]  d2_reg, s2_reg, d3_reg, s3_reg;
    logic signed [SUM_W-1:0]    sum_next, sum_reg;
    logic signed [Q_W-1:0]      quot;
    logic signed [V_W-1:0]      val;
    logic signed [COORD_W-1:0]  sat;
    logic signed [COORD_W-1:0]  point_reg, point_next;

    assign ca_s = $signed({1'b0, coef_a});
    assign cb_s = $signed({1'b0, coef_b});
    assign cc_s = $signed({1'b0, coef_c});

    assign pa_next = P_W'(ca_s) * P_W'($signed(terms.a));
    assign pb_next = P_W'(cb_s) * P_W'($signed(terms.b));
    assign pc_next = P_W'(cc_s) * P_W'($signed(terms.c));

    assign sum_next = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg);

    // floor division by the coefficient scale
    assign quot = $signed(sum_reg[SUM_W-1:COEF_FRAC_BITS]);
    assign val = V_W'(quot) + V_W'(d3_reg);

    always_comb
    begin
        if (val > V_W'(COORD_MAX))
        begin
            sat = COORD_MAX;
        end
        else if (val < V_W'(COORD_MIN))
        begin
            sat = COORD_MIN;
        end
        else
        begin
            sat = val[COORD_W-1:0];
        end
    end

    // endpoints bypass the polynomial
    always_comb
    begin
        if (ctrl.first)
        begin
            point_next = d3_reg;
        end
        else if (ctrl.last)
        begin
            point_next = s3_reg;
        end
        else
        begin
            point_next = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            d2_reg <= terms.d;
            s2_reg <= terms.s;
            sum_reg <= sum_next;
            d3_reg <= d2_reg;
            s3_reg <= s2_reg;
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

FILE: src/cubic_bezier_flattener_unit.sv
// cubic bezier flattener top level: intake, coefficient stage, two coordinate pipes
// an accepted curve issues from index 0; points pass valid1_reg through valid4_reg
// throughput: one point per cycle while the output is taken, a new curve accepted
// as the last index issues; set by the sample sequencer, which issues one index per
// cycle into the pipe; the whole pipe holds when a finished point is not taken
// reset clears the sequencer and all valid bits, data registers are not reset
module cubic_bezier_flattener_unit #(
    parameter int NUM_POINTS = cbf_pkg::NUM_POINTS_DEF,
    parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_a_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_a_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_b_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl_b_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [cbf_pkg::COORD_W-1:0] point_x,
    output logic signed [cbf_pkg::COORD_W-1:0] point_y,
    output logic [cbf_pkg::IDX_W-1:0]          point_index,
    output logic                               last_point
);
    import cbf_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

    logic       advance;
    logic       issue_valid;
    cbf_ctrl_t  issue_ctrl;
    cbf_terms_t issue_tx, issue_ty;
    logic [CW-1:0] rom_a, rom_b, rom_c;

    logic       valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    cbf_ctrl_t  ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    logic [CW-1:0] ca1_reg, cb1_reg, cc1_reg;
    cbf_terms_t tx1_reg, ty1_reg;

    assign advance = !valid4_reg || out_ready;

    cbf_issue #(
        .NUM_POINTS(NUM_POINTS)
    ) u_issue (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_x(start_x),
        .start_y(start_y),
        .end_x(end_x),
        .end_y(end_y),
        .ctrl_a_x(ctrl_a_x),
        .ctrl_a_y(ctrl_a_y),
        .ctrl_b_x(ctrl_b_x),
        .ctrl_b_y(ctrl_b_y),
        .advance(advance),
        .issue_valid(issue_valid),
        .issue_ctrl(issue_ctrl),
        .terms_x(issue_tx),
        .terms_y(issue_ty)
    );

    cbf_coef_rom #(
        .NUM_POINTS(NUM_POINTS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_coef_rom (
        .index(issue_ctrl.index),
        .coef_a(rom_a),
        .coef_b(rom_b),
        .coef_c(rom_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= issue_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctrl1_reg <= issue_ctrl;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            ca1_reg <= rom_a;
            cb1_reg <= rom_b;
            cc1_reg <= rom_c;
            tx1_reg <= issue_tx;
            ty1_reg <= issue_ty;
        end
    end

    cbf_coord_path #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_path_x (
        .clk(clk),
        .advance(advance),
        .coef_a(ca1_reg),
        .coef_b(cb1_reg),
        .coef_c(cc1_reg),
        .terms(tx1_reg),
        .ctrl(ctrl3_reg),
        .point(point_x)
    );

    cbf_coord_path #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_path_y (
        .clk(clk),
        .advance(advance),
        .coef_a(ca1_reg),
        .coef_b(cb1_reg),
        .coef_c(cc1_reg),
        .terms(ty1_reg),
        .ctrl(ctrl3_reg),
        .point(point_y)
    );

    assign out_valid = valid4_reg;
    assign point_index = ctrl4_reg.index;
    assign last_point = ctrl4_reg.last;

    // last flag only on the final index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_point == (point_index == LAST_IDX)))
        else $error("last flag does not match final index");

    // points of one curve leave back to back in index order
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_point |=>
            out_valid && (point_index == $past(point_index) + 1'b1))
        else $error("point index sequence broken");

    // a freshly accepted curve blocks intake until its last index issues
    a_intake_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("curve accepted while previous one still issuing");

endmodule
